>>> rtl/core/rank_range_list_parser_defines.svh
// Assertion macros for the rank range-list parser.
// Each expands to a labeled concurrent assertion clocked on clk_i and
// disabled while rst_ni is low.
`ifndef RANK_RANGE_LIST_PARSER_DEFINES_SVH
`define RANK_RANGE_LIST_PARSER_DEFINES_SVH

// Same-cycle implication
`define RRLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RRLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rrlp_pkg.sv
package rrlp_pkg;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int QUERY_W  = 12;
  localparam int WORLD_W  = 13;
  localparam int STATUS_W = 2;

  // Width of a parsed number and of the bitmap epoch tag
  localparam int NUM_W   = 31;
  localparam int EPOCH_W = 8;

  // Configuration register indexes
  typedef enum logic {
    REG_QUERY = 1'b0,
    REG_WORLD = 1'b1
  } rrlp_reg_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;      // accept one character
    logic walk_rd;   // read bitmap at walk index
    logic walk_chk;  // check and mark bitmap entry
    logic clr_wr;    // clearing pass write
    logic finish;    // load result, reset per-string state
  } rrlp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_nul;      // current character ends the string
    logic walk_go;     // current character closes a non-empty in-bounds range
    logic rd_stop;     // walk index reached the rank limit
    logic chk_stop;    // duplicate found or last rank of range
    logic clr_done;    // clearing pass at last entry
    logic epoch_last;  // epoch tag about to wrap
  } rrlp_sts_t;

endpackage

>>> rtl/core/rank_range_list_parser.sv
// Channel   Direction  Handshake                Payload
// config    in         psel/penable/pready      paddr, pwdata, prdata
// in        in         in_valid_i/in_stall_o    char_code_i
// out       out        out_valid_o/out_stall_i  status_o, within_range_o, total_ranks_o
//
// A character that closes no range is taken straight from idle; the end-of-string
// byte then passes through the finish state. Closing a range walks the rank bitmap
// rank by rank (read, then check and mark), bounded by the rank limit.
// After reset, and after every 255th string, a clearing pass runs over every bitmap
// entry; input is stalled then, register writes are still taken.
// A waiting result does not block input; only the next end-of-string byte waits.
`include "rank_range_list_parser_defines.svh"

module rank_range_list_parser import rrlp_pkg::*; #(
  parameter int MAX_RANKS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CHAR_W-1:0]   char_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                within_range_o,
  output logic [WORLD_W-1:0]  total_ranks_o
);

  logic [QUERY_W-1:0] query_q, query_d;
  logic [WORLD_W-1:0] world_q, world_d;
  logic               cfg_wr;
  rrlp_reg_e          reg_sel;
  rrlp_cmd_t          cmd;
  rrlp_sts_t          sts;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = rrlp_reg_e'(paddr[2]);

  always_comb begin
    query_d = query_q;
    world_d = world_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_QUERY: query_d = pwdata[QUERY_W-1:0];
        REG_WORLD: world_d = pwdata[WORLD_W-1:0];
        default:   query_d = query_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_QUERY: prdata = {{(32-QUERY_W){1'b0}}, query_q};
      REG_WORLD: prdata = {{(32-WORLD_W){1'b0}}, world_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
      world_q <= WORLD_W'(4096);
    end else begin
      query_q <= query_d;
      world_q <= world_d;
    end
  end

  rrlp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrlp_dp #(
    .MAX_RANKS (MAX_RANKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .char_code_i    (char_code_i),
    .query_rank_i   (query_q),
    .world_size_i   (world_q),
    .status_o       (status_o),
    .within_range_o (within_range_o),
    .total_ranks_o  (total_ranks_o)
  );

  // Checks
  `RRLP_ASSERT_IMP(a_chk_after_rd, cmd.walk_chk, $past(cmd.walk_rd), "check without read")
  `RRLP_ASSERT_IMP(a_no_in_clear, cmd.clr_wr, in_stall_o, "input taken during clear")
  `RRLP_ASSERT_NXT(a_finish_out, cmd.finish, out_valid_o, "result load lost")

endmodule

>>> rtl/core/rrlp_ram.sv
module rrlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rrlp_dp.sv
module rrlp_dp import rrlp_pkg::*; #(
  parameter int MAX_RANKS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrlp_cmd_t           cmd_i,
  output rrlp_sts_t           sts_o,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [QUERY_W-1:0]  query_rank_i,
  input  logic [WORLD_W-1:0]  world_size_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                within_range_o,
  output logic [WORLD_W-1:0]  total_ranks_o
);

  localparam int AW = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int IW = $clog2(MAX_RANKS + 1);

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

  localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_LOW   = 3'd1,
    PH_DASH  = 3'd2,
    PH_HIGH  = 3'd3,
    PH_SEEK  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KW_NONE = 3'd0,
    KW_A    = 3'd1,
    KW_AL   = 3'd2,
    KW_ALL  = 3'd3,
    KW_STAR = 3'd4,
    KW_DEAD = 3'd7
  } kw_e;

  typedef enum logic [STATUS_W-1:0] {
    ERR_OK      = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_RANGE   = 2'd2,
    ERR_DUP     = 2'd3
  } err_e;

  // acc * 10 + digit, saturating
  function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] dig);
    logic [NUM_W+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, dig};
    return (|v[NUM_W+3:NUM_W]) ? NUM_SAT : v[NUM_W-1:0];
  endfunction

  function automatic kw_e kw_next(input kw_e kw, input logic [CHAR_W-1:0] c);
    kw_e nx;
    case (kw)
      KW_NONE: nx = (c == CH_A) ? KW_A : ((c == CH_STAR) ? KW_STAR : KW_DEAD);
      KW_A:    nx = (c == CH_L) ? KW_AL : KW_DEAD;
      KW_AL:   nx = (c == CH_L) ? KW_ALL : KW_DEAD;
      default: nx = KW_DEAD;
    endcase
    return nx;
  endfunction

  phase_e             phase_q, phase_d;
  kw_e                kw_q, kw_d;
  err_e               err_q, err_d;
  logic               found_q, found_d;
  logic [WORLD_W-1:0] count_q, count_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [NUM_W-1:0]   low_q, low_d;
  logic [NUM_W-1:0]   high_q, high_d;
  logic [NUM_W-1:0]   end_q, end_d;

  logic [STATUS_W-1:0] status_q, status_d;
  logic                within_q, within_d;
  logic [WORLD_W-1:0]  total_q, total_d;

  logic               ram_we;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [EPOCH_W-1:0] ram_rdata;

  logic             is_dig, is_nul, is_dash, kw_hit, close, rng_empty, rng_oob, dup;
  logic [3:0]       dig_val;
  logic [NUM_W-1:0] hi_sel, lim, ws_ext, max_ext, idx_ext, q_ext;
  logic [CHAR_W-1:0] dig_off;

  // Character decode
  assign is_dig  = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign dig_off = char_code_i - CH_ZERO;
  assign dig_val = dig_off[3:0];
  assign is_nul  = (char_code_i == CH_NUL);
  assign is_dash = (char_code_i == CH_DASH);
  assign kw_hit  = (kw_q == KW_ALL) || (kw_q == KW_STAR);

  // Range bounds and rank limit
  assign hi_sel  = (phase_q == PH_HIGH) ? high_q : low_q;
  assign ws_ext  = {{(NUM_W-WORLD_W){1'b0}}, world_size_i};
  assign max_ext = NUM_W'(MAX_RANKS);
  assign lim     = (ws_ext < max_ext) ? ws_ext : max_ext;
  assign idx_ext = {{(NUM_W-IW){1'b0}}, idx_q};
  assign q_ext   = {{(NUM_W-QUERY_W){1'b0}}, query_rank_i};

  // Does this character close a range
  always_comb begin
    close = 1'b0;
    if (err_q == ERR_OK) begin
      if (is_nul) begin
        close = !kw_hit && ((phase_q == PH_LOW) || (phase_q == PH_DASH) ||
                            (phase_q == PH_HIGH));
      end else begin
        close = ((phase_q == PH_LOW) && !is_dig && !is_dash) ||
                ((phase_q == PH_DASH) && !is_dig) ||
                ((phase_q == PH_HIGH) && !is_dig);
      end
    end
  end

  assign rng_empty = low_q > hi_sel;
  assign rng_oob   = low_q >= lim;
  assign dup       = (ram_rdata == epoch_q);

  assign sts_o.is_nul     = is_nul;
  assign sts_o.walk_go    = close && !rng_empty && !rng_oob;
  assign sts_o.rd_stop    = idx_ext >= lim;
  assign sts_o.chk_stop   = dup || (idx_ext == end_q);
  assign sts_o.clr_done   = (idx_q == IW'(MAX_RANKS - 1));
  assign sts_o.epoch_last = &epoch_q;

  // Bitmap write port
  assign ram_we    = cmd_i.clr_wr || (cmd_i.walk_chk && !dup);
  assign ram_wdata = cmd_i.clr_wr ? '0 : epoch_q;

  // Next-state logic
  always_comb begin
    phase_d  = phase_q;
    kw_d     = kw_q;
    err_d    = err_q;
    found_d  = found_q;
    count_d  = count_q;
    epoch_d  = epoch_q;
    idx_d    = idx_q;
    low_d    = low_q;
    high_d   = high_q;
    end_d    = end_q;
    status_d = status_q;
    within_d = within_q;
    total_d  = total_q;

    if (cmd_i.step) begin
      if (!is_nul) begin
        kw_d = kw_next(kw_q, char_code_i);
        if (err_q == ERR_OK) begin
          case (phase_q)
            PH_START: begin
              if (is_dig) begin
                low_d   = {{(NUM_W-4){1'b0}}, dig_val};
                phase_d = PH_LOW;
              end else begin
                err_d   = ERR_INVALID;
                phase_d = PH_SEEK;
              end
            end
            PH_LOW: begin
              if (is_dig) begin
                low_d = acc_digit(low_q, dig_val);
              end else if (is_dash) begin
                phase_d = PH_DASH;
              end else begin
                phase_d = PH_SEEK;
              end
            end
            PH_DASH: begin
              if (is_dig) begin
                high_d  = {{(NUM_W-4){1'b0}}, dig_val};
                phase_d = PH_HIGH;
              end else begin
                phase_d = PH_SEEK;
              end
            end
            PH_HIGH: begin
              if (is_dig) begin
                high_d = acc_digit(high_q, dig_val);
              end else begin
                phase_d = PH_SEEK;
              end
            end
            default: begin
              if (is_dig) begin
                low_d   = {{(NUM_W-4){1'b0}}, dig_val};
                phase_d = PH_LOW;
              end
            end
          endcase
        end
      end else if (!kw_hit && (err_q == ERR_OK) && (phase_q == PH_START)) begin
        err_d = ERR_INVALID;
      end
      // Closing range: start the walk or flag a low end past the limit
      if (close && !rng_empty) begin
        if (rng_oob) begin
          err_d = ERR_RANGE;
        end else begin
          idx_d = low_q[IW-1:0];
          end_d = hi_sel;
        end
      end
    end

    if (cmd_i.walk_rd && sts_o.rd_stop) begin
      err_d = ERR_RANGE;
    end

    if (cmd_i.walk_chk) begin
      if (dup) begin
        err_d = ERR_DUP;
      end else begin
        count_d = count_q + 1'b1;
        if (idx_ext == end_q) begin
          if ((q_ext >= low_q) && (q_ext <= end_q)) begin
            found_d = 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end

    if (cmd_i.clr_wr) begin
      idx_d = idx_q + 1'b1;
    end

    // End of string: load result, drop per-string state, move epoch
    if (cmd_i.finish) begin
      if (kw_hit) begin
        status_d = ERR_OK;
        within_d = 1'b1;
        total_d  = world_size_i;
      end else begin
        status_d = err_q;
        within_d = (err_q == ERR_OK) ? found_q : 1'b0;
        total_d  = (err_q == ERR_OK) ? count_q : '0;
      end
      phase_d = PH_START;
      kw_d    = KW_NONE;
      err_d   = ERR_OK;
      found_d = 1'b0;
      count_d = '0;
      epoch_d = (&epoch_q) ? EPOCH_W'(1) : epoch_q + 1'b1;
      idx_d   = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      kw_q    <= KW_NONE;
      err_q   <= ERR_OK;
      found_q <= 1'b0;
      count_q <= '0;
      epoch_q <= EPOCH_W'(1);
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      kw_q    <= kw_d;
      err_q   <= err_d;
      found_q <= found_d;
      count_q <= count_d;
      epoch_q <= epoch_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    high_q   <= high_d;
    end_q    <= end_d;
    status_q <= status_d;
    within_q <= within_d;
    total_q  <= total_d;
  end

  // Rank bitmap, one epoch tag per rank
  rrlp_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (MAX_RANKS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (idx_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign status_o       = status_q;
  assign within_range_o = within_q;
  assign total_ranks_o  = total_q;

endmodule

>>> rtl/core/rrlp_ctrl.sv
module rrlp_ctrl import rrlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  rrlp_sts_t sts_i,
  output rrlp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   eos_q, eos_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Sequencing
  always_comb begin
    state_d     = state_q;
    eos_d       = eos_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          eos_d      = sts_i.is_nul;
          if (sts_i.walk_go) begin
            state_d = ST_WALK_RD;
          end else if (sts_i.is_nul) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        if (sts_i.rd_stop) begin
          state_d = eos_q ? ST_FINISH : ST_IDLE;
        end else begin
          state_d = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        cmd_o.walk_chk = 1'b1;
        if (sts_i.chk_stop) begin
          state_d = eos_q ? ST_FINISH : ST_IDLE;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = sts_i.epoch_last ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      eos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      eos_q       <= eos_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sim/rank_range_list_parser_tb.sv
`timescale 1ns / 1ps

module rank_range_list_parser_tb;
  import rrlp_pkg::*;

  // Parser scan phase and keyword tracker of the predictor
  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_LOW,
    SCAN_DASH,
    SCAN_HIGH,
    SCAN_SKIP
  } scan_e;

  typedef enum logic [2:0] {
    KW_EMPTY = 3'd0,
    KW_A     = 3'd1,
    KW_AL    = 3'd2,
    KW_ALL   = 3'd3,
    KW_STAR  = 3'd4,
    KW_FAIL  = 3'd7
  } keyword_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BEYOND    = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                in_range;
    logic [WORLD_W-1:0]  total;
  } parse_result_t;

  localparam int          RANK_LIMIT    = 4096;
  localparam logic [30:0] NUM_MAX       = 31'h7FFF_FFFF;
  localparam int          RAND_ITEMS    = 1880;
  localparam int          RAND_PHASES   = 8;
  localparam int          DRAIN_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 24;

  // DUT signals
  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CHAR_W-1:0]   char_code_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic                within_range_o;
  logic [WORLD_W-1:0]  total_ranks_o;

  rank_range_list_parser #(
    .MAX_RANKS(RANK_LIMIT)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .within_range_o(within_range_o),
    .total_ranks_o (total_ranks_o)
  );

  // Predictor state: registers and per-string parse state
  logic [QUERY_W-1:0] query_q;
  logic [WORLD_W-1:0] world_q;
  bit                 rank_marked [RANK_LIMIT];
  scan_e              scan;
  keyword_e           kw;
  logic [30:0]        lo_num;
  logic [30:0]        hi_num;
  logic [WORLD_W-1:0] rank_count;
  logic               hit;
  status_e            err;

  parse_result_t pending_results [$];
  logic [7:0]    line_buf [$];

  bit idle_on;
  int mismatches;
  int chars_sent;
  int strings_sent;
  int results_checked;
  int reg_writes;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #200_000_000;
    $display("rank_range_list_parser regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Per-string state back to its start
  task clear_string();
    rank_marked = '{default: 1'b0};
    scan       = SCAN_START;
    kw         = KW_EMPTY;
    lo_num     = '0;
    hi_num     = '0;
    rank_count = '0;
    hit        = 1'b0;
    err        = ST_OK;
  endtask

  function automatic logic [30:0] add_digit(logic [30:0] acc, logic [3:0] d);
    logic [34:0] v;
    v = acc * 35'd10 + d;
    return (v > NUM_MAX) ? NUM_MAX : v[30:0];
  endfunction

  function automatic keyword_e next_kw(keyword_e k, logic [7:0] c);
    case (k)
      KW_EMPTY: return (c == "a") ? KW_A : ((c == "*") ? KW_STAR : KW_FAIL);
      KW_A:     return (c == "l") ? KW_AL : KW_FAIL;
      KW_AL:    return (c == "l") ? KW_ALL : KW_FAIL;
      default:  return KW_FAIL;
    endcase
  endfunction

  // Walk a closed range upward, marking ranks; stops at the first error
  task mark_span(input logic [30:0] lo, input logic [30:0] hi);
    int unsigned lim;
    int unsigned r;
    lim = (world_q < RANK_LIMIT) ? world_q : RANK_LIMIT;
    if (lo > hi) return;
    for (r = lo; r <= hi; r++) begin
      if (r >= lim) begin
        err = ST_BEYOND;
        return;
      end
      if (rank_marked[r]) begin
        err = ST_DUPLICATE;
        return;
      end
      rank_marked[r] = 1'b1;
      rank_count     = rank_count + 1'b1;
    end
    if (query_q >= lo && query_q <= hi) hit = 1'b1;
  endtask

  // Predict the effect of one accepted character
  task parse_char(input logic [7:0] c);
    logic          is_digit;
    logic [3:0]    d;
    parse_result_t res;
    is_digit = (c >= "0") && (c <= "9");
    d        = c[3:0];
    if (c == 8'd0) begin
      if (kw == KW_ALL || kw == KW_STAR) begin
        res.status   = ST_OK;
        res.in_range = 1'b1;
        res.total    = world_q;
      end else begin
        if (err == ST_OK) begin
          case (scan)
            SCAN_START:          err = ST_BAD_START;
            SCAN_LOW, SCAN_DASH: mark_span(lo_num, lo_num);
            SCAN_HIGH:           mark_span(lo_num, hi_num);
            default: ;
          endcase
        end
        res.status   = err;
        res.in_range = (err == ST_OK) ? hit : 1'b0;
        res.total    = (err == ST_OK) ? rank_count : '0;
      end
      pending_results.push_back(res);
      strings_sent++;
      clear_string();
    end else begin
      kw = next_kw(kw, c);
      if (err == ST_OK) begin
        case (scan)
          SCAN_START: begin
            if (is_digit) begin
              lo_num = 31'(d);
              scan   = SCAN_LOW;
            end else begin
              err  = ST_BAD_START;
              scan = SCAN_SKIP;
            end
          end
          SCAN_LOW: begin
            if (is_digit) begin
              lo_num = add_digit(lo_num, d);
            end else if (c == "-") begin
              scan = SCAN_DASH;
            end else begin
              mark_span(lo_num, lo_num);
              scan = SCAN_SKIP;
            end
          end
          SCAN_DASH: begin
            if (is_digit) begin
              hi_num = 31'(d);
              scan   = SCAN_HIGH;
            end else begin
              mark_span(lo_num, lo_num);
              scan = SCAN_SKIP;
            end
          end
          SCAN_HIGH: begin
            if (is_digit) begin
              hi_num = add_digit(hi_num, d);
            end else begin
              mark_span(lo_num, hi_num);
              scan = SCAN_SKIP;
            end
          end
          default: begin
            if (is_digit) begin
              lo_num = 31'(d);
              scan   = SCAN_LOW;
            end
          end
        endcase
      end
    end
  endtask

  // One character transfer, at times with a random gap ahead of it
  task send_char(input logic [7:0] c);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    parse_char(c);
  endtask

  task push_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Send the buffered string followed by its terminator
  task send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    send_char(8'd0);
    line_buf.delete();
  endtask

  task send_str(input string s);
    line_buf.delete();
    push_str(s);
    send_line();
  endtask

  // Stop input and wait for every expected result, then let the block settle
  task wait_idle();
    int guard;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task write_reg(input rrlp_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_QUERY) query_q = value[QUERY_W-1:0];
    else                  world_q = value[WORLD_W-1:0];
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper bits of each write are random; only the field bits count
  task set_regs(input int unsigned q, input int unsigned w);
    wait_idle();
    write_reg(REG_QUERY, ($urandom() & 32'hFFFF_F000) | q);
    write_reg(REG_WORLD, ($urandom() & 32'hFFFF_E000) | w);
  endtask

  // Random stimulus helpers
  task push_number(input longint unsigned v);
    if ($urandom_range(0, 7) == 0) line_buf.push_back("0");
    push_str($sformatf("%0d", v));
  endtask

  function automatic longint unsigned pick_rank(int unsigned lim, longint unsigned prev);
    int unsigned q;
    q = 32'(query_q);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 15);
      4, 5:       return (q > 3) ? q - 3 + $urandom_range(0, 6) : $urandom_range(0, 6);
      6, 7:       return $urandom_range(0, lim);
      8:          return prev;
      default:    return longint'($urandom()) * 100 + $urandom_range(0, 99);
    endcase
  endfunction

  function automatic longint unsigned pick_high(longint unsigned lo);
    case ($urandom_range(0, 15))
      0:       return (lo > 0) ? lo - $urandom_range(1, (lo > 5) ? 5 : 32'(lo)) : lo;
      1:       return lo + $urandom_range(0, 300);
      2:       return longint'($urandom()) * 100;
      default: return lo + $urandom_range(0, 12);
    endcase
  endfunction

  task push_separator();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      6: push_str(" ");
      7: push_str(";");
      8: begin
        do b = 8'($urandom_range(1, 255)); while ((b >= "0" && b <= "9") || b == "-");
        line_buf.push_back(b);
      end
      9:       push_str(",,");
      default: push_str(",");
    endcase
  endtask

  // Mostly well-formed lists, some keyword forms, some raw noise
  task send_random_line();
    int              kind;
    int              n;
    int unsigned     lim;
    longint unsigned lo;
    longint unsigned prev;
    lim  = (world_q < RANK_LIMIT) ? world_q : RANK_LIMIT;
    kind = $urandom_range(0, 19);
    prev = 0;
    line_buf.delete();
    if (kind < 15) begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        if (k != 0) push_separator();
        lo   = pick_rank(lim, prev);
        prev = lo;
        push_number(lo);
        case ($urandom_range(0, 9))
          4, 5, 6, 7, 8: begin
            push_str("-");
            push_number(pick_high(lo));
            if ($urandom_range(0, 7) == 0) push_str("-");
          end
          9:       push_str("-");
          default: ;
        endcase
      end
      if ($urandom_range(0, 5) == 0) push_separator();
    end else if (kind < 17) begin
      case ($urandom_range(0, 6))
        0:       push_str("all");
        1:       push_str("*");
        2:       push_str("al");
        3:       push_str("a");
        4:       push_str("alll");
        5:       push_str("*5");
        default: push_str("all,3");
      endcase
    end else begin
      n = $urandom_range(0, 8);
      repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
    end
    send_line();
  endtask

  // Directed tests
  task test_keywords();
    send_str("all");
    send_str("*");
    send_str("al");
  endtask

  task test_bad_start();
    send_str("");
    line_buf.delete();
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  task test_lists();
    set_regs(7, 16);
    send_str("3,5-9");
    send_str("9-7");
    send_str("3-,7-");
    send_str("1-2-3 007");
  endtask

  task test_errors();
    set_regs(0, 4);
    send_str("2,2");
    send_str("9,1,1");
    send_str("99999999999");
    set_regs(4095, 4096);
    send_str("0-4095");
    set_regs(4095, 0);
    send_str("0");
    set_regs(0, 8191);
    send_str("*");
  endtask

  task test_random();
    int unsigned w;
    int unsigned q;
    int          target;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       w = 4096;
        1:       w = $urandom_range(2, 64);
        2:       w = 1;
        3:       w = 8191;
        4:       w = 0;
        5:       w = $urandom_range(4097, 8191);
        6:       w = 4095;
        default: w = $urandom_range(1, 200);
      endcase
      case (phase)
        3:       q = 4095;
        4:       q = 0;
        default: q = $urandom_range(0, (w > 4096) ? 4095 : ((w > 0) ? w - 1 : 0));
      endcase
      set_regs(q, w);
      idle_on = (phase != RAND_PHASES - 1);
      target  = chars_sent + RAND_ITEMS / RAND_PHASES;
      while (chars_sent < target) send_random_line();
    end
  endtask

  // Output stall in random bursts
  initial begin : stall_gen
    int stall_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
      out_stall_i <= (stall_left != 0);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    parse_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d within=%0d total=%0d",
                                  status_o, within_range_o, total_ranks_o));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status_o !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_checked, status_o, want.status));
        if (within_range_o !== want.in_range)
          report_mismatch($sformatf("result %0d within_range %0d, want %0d",
                                    results_checked, within_range_o, want.in_range));
        if (total_ranks_o !== want.total)
          report_mismatch($sformatf("result %0d total_ranks %0d, want %0d",
                                    results_checked, total_ranks_o, want.total));
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    rst_ni      = 1'b0;
    idle_on     = 1'b1;
    query_q     = '0;
    world_q     = 13'd4096;
    clear_string();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_keywords();
    test_bad_start();
    test_lists();
    test_errors();
    test_random();

    wait_idle();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Parsed %0d strings (%0d characters) over keyword, list, range and error cases,",
             strings_sent, chars_sent);
    $display("with %0d register writes; %0d results checked, %0d mismatches.",
             reg_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("rank_range_list_parser regression: pass");
    end else begin
      $display("rank_range_list_parser regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rrlp_pkg.sv
rtl/core/rrlp_ram.sv
rtl/core/rrlp_dp.sv
rtl/core/rrlp_ctrl.sv
rtl/core/rank_range_list_parser.sv
sim/rank_range_list_parser_tb.sv
